// ----- design/bam_pkg.sv -----
// ----------------------------------------------------------------------------
// bam_pkg
// Shared widths, command codes, entry codes and hit codes for the
// breakpoint address map.
// ----------------------------------------------------------------------------
`default_nettype none

package bam_pkg;

   // map geometry
   localparam int ADDR_BITS = 16;
   localparam int ID_BITS   = 8;
   localparam int MAP_DEPTH = 1 << ADDR_BITS;

   // port field widths
   localparam int CMD_W    = 4;
   localparam int F_ADDR_W = 16;
   localparam int F_ID_W   = 8;
   localparam int VALUE_W  = 16;
   localparam int HIT_W    = 2;

   typedef logic [CMD_W-1:0]     cmd_type;
   typedef logic [ID_BITS-1:0]   code_type;
   typedef logic [ADDR_BITS-1:0] maddr_type;
   typedef logic [HIT_W-1:0]     hit_type;

   localparam cmd_type CMD_ADD        = 4'd0;
   localparam cmd_type CMD_CLEAR      = 4'd1;
   localparam cmd_type CMD_CLEAR_ADDR = 4'd2;
   localparam cmd_type CMD_CLEAR_ID   = 4'd3;
   localparam cmd_type CMD_FIND_ADDR  = 4'd4;
   localparam cmd_type CMD_READ       = 4'd5;
   localparam cmd_type CMD_SET_TEMP   = 4'd6;
   localparam cmd_type CMD_RESET_TEMP = 4'd7;
   localparam cmd_type CMD_CLEAR_ALL  = 4'd8;
   localparam cmd_type CMD_EXECUTE    = 4'd9;

   localparam code_type CODE_NONE = '0;
   localparam code_type CODE_TEMP = '1;

   localparam hit_type HIT_NONE = 2'd0;
   localparam hit_type HIT_BP   = 2'd1;
   localparam hit_type HIT_TEMP = 2'd2;

endpackage

`default_nettype wire

// ----- design/bam_ram.sv -----
// ----------------------------------------------------------------------------
// bam_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bam_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// ----- design/breakpoint_address_map.sv -----
// ----------------------------------------------------------------------------
// breakpoint_address_map
// Breakpoint code per address with one temporary breakpoint; add, clear,
// search, read, temporary set/reset, clear-all and execute check.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one command item (cmd, addr, bp_id); rsp_* returns exactly
//   one result item (value, found, hit_kind) per command, in order.
//   req_stall is high whenever the sequencer is busy; one item is in work at
//   a time. The map lives in a 64K x 8 RAM with one read and one write port.
//   Steps from accept to rsp_valid: for add, clear, clear_addr, read,
//   reset_temp, execute and unknown codes: read, decide, register; for
//   set_temp: old marker removed, then new entry read, then register.
//   clear_id and find_addr scan the RAM one address per cycle from address
//   0, up to the last address. clear_all sweeps the RAM one entry per cycle.
//   A new item is accepted only after the result of the last one is
//   registered. After reset a clearing pass over all 2^16 entries runs
//   with req_stall high. A stalled result stays in the output register;
//   the sequencer holds its next result until that register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module breakpoint_address_map (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic [bam_pkg::CMD_W-1:0]    req_cmd,
   input  wire logic [bam_pkg::F_ADDR_W-1:0] req_addr,
   input  wire logic [bam_pkg::F_ID_W-1:0]   req_bp_id,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic [bam_pkg::VALUE_W-1:0]    rsp_value,
   output logic                           rsp_found,
   output logic [bam_pkg::HIT_W-1:0]      rsp_hit_kind
);

   import bam_pkg::*;

   localparam logic [2:0] ST_IDLE      = 3'd0;
   localparam logic [2:0] ST_LOOK      = 3'd1;
   localparam logic [2:0] ST_SCAN      = 3'd2;
   localparam logic [2:0] ST_TEMP_RD   = 3'd3;
   localparam logic [2:0] ST_TEMP_LOOK = 3'd4;
   localparam logic [2:0] ST_POST      = 3'd5;
   localparam logic [2:0] ST_CLEAR     = 3'd6;

   logic [2:0]   state_ff, state_in;
   cmd_type      cmd_ff, cmd_in;
   maddr_type    addr_ff, addr_in;
   code_type     id_ff, id_in;
   maddr_type    scan_ff, scan_in;
   maddr_type    clr_ff, clr_in;
   logic         post_ff, post_in;
   maddr_type    temp_addr_ff, temp_addr_in;
   logic         temp_valid_ff, temp_valid_in;
   logic [VALUE_W-1:0] res_value_ff, res_value_in;
   logic         res_found_ff, res_found_in;
   hit_type      res_hit_ff, res_hit_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic         rsp_found_ff, rsp_found_in;
   hit_type      rsp_hit_ff, rsp_hit_in;

   logic         wr_en;
   maddr_type    wr_addr;
   code_type     wr_data;
   maddr_type    rd_addr;
   code_type     rd_data;

   logic         id_ok;
   logic         e_is_id;
   logic         at_temp;

   bam_ram #(
      .WIDTH (ID_BITS),
      .DEPTH (MAP_DEPTH)
   ) u_map (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign id_ok   = (id_ff != CODE_NONE) && (id_ff != CODE_TEMP);
   assign e_is_id = (rd_data != CODE_NONE) && (rd_data != CODE_TEMP);
   assign at_temp = temp_valid_ff && (temp_addr_ff == addr_ff);

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      addr_in       = addr_ff;
      id_in         = id_ff;
      scan_in       = scan_ff;
      clr_in        = clr_ff;
      post_in       = post_ff;
      temp_addr_in  = temp_addr_ff;
      temp_valid_in = temp_valid_ff;
      res_value_in  = res_value_ff;
      res_found_in  = res_found_ff;
      res_hit_in    = res_hit_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_hit_in    = rsp_hit_ff;
      wr_en         = 1'b0;
      wr_addr       = addr_ff;
      wr_data       = CODE_NONE;
      rd_addr       = addr_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_cmd == CMD_SET_TEMP || req_cmd == CMD_RESET_TEMP) begin
               rd_addr = temp_addr_ff;
            end else begin
               rd_addr = req_addr[ADDR_BITS-1:0];
            end
            if (req_valid) begin
               cmd_in       = req_cmd;
               addr_in      = req_addr[ADDR_BITS-1:0];
               id_in        = req_bp_id[ID_BITS-1:0];
               res_value_in = '0;
               res_found_in = 1'b0;
               res_hit_in   = HIT_NONE;
               state_in     = ST_LOOK;
            end
         end
         ST_LOOK: begin
            // scans start at address 0
            rd_addr  = '0;
            state_in = ST_POST;
            case (cmd_ff)
               CMD_ADD: begin
                  if (id_ok) begin
                     if (e_is_id) begin
                        res_value_in = VALUE_W'(rd_data);
                     end else begin
                        wr_en   = 1'b1;
                        wr_data = id_ff;
                     end
                  end
               end
               CMD_CLEAR: begin
                  if (id_ok && rd_data == id_ff) begin
                     wr_en        = 1'b1;
                     wr_data      = at_temp ? CODE_TEMP : CODE_NONE;
                     res_found_in = 1'b1;
                  end
               end
               CMD_CLEAR_ADDR: begin
                  if (e_is_id) begin
                     res_found_in = 1'b1;
                  end
                  if (at_temp) begin
                     wr_en   = 1'b1;
                     wr_data = CODE_TEMP;
                  end else if (e_is_id) begin
                     wr_en   = 1'b1;
                     wr_data = CODE_NONE;
                  end
               end
               CMD_CLEAR_ID, CMD_FIND_ADDR: begin
                  if (id_ok) begin
                     scan_in  = '0;
                     state_in = ST_SCAN;
                  end
               end
               CMD_READ: begin
                  res_value_in = VALUE_W'(rd_data);
               end
               CMD_SET_TEMP, CMD_RESET_TEMP: begin
                  // rd_data holds the entry at the old temporary address
                  if (temp_valid_ff) begin
                     if (rd_data == CODE_TEMP) begin
                        wr_en   = 1'b1;
                        wr_addr = temp_addr_ff;
                        wr_data = CODE_NONE;
                     end
                     temp_valid_in = 1'b0;
                  end
                  if (cmd_ff == CMD_SET_TEMP) begin
                     temp_addr_in  = addr_ff;
                     temp_valid_in = 1'b1;
                     state_in      = ST_TEMP_RD;
                  end
               end
               CMD_CLEAR_ALL: begin
                  temp_addr_in  = '0;
                  temp_valid_in = 1'b0;
                  clr_in        = '0;
                  post_in       = 1'b1;
                  state_in      = ST_CLEAR;
               end
               CMD_EXECUTE: begin
                  if (e_is_id) begin
                     res_hit_in = HIT_BP;
                  end else if (at_temp) begin
                     res_hit_in = HIT_TEMP;
                  end
               end
               default: begin
               end
            endcase
         end
         ST_SCAN: begin
            // rd_data holds the entry at scan_ff; fetch the next one
            rd_addr = scan_ff + maddr_type'(1);
            if (rd_data == id_ff) begin
               res_found_in = 1'b1;
               if (cmd_ff == CMD_CLEAR_ID) begin
                  wr_en   = 1'b1;
                  wr_addr = scan_ff;
                  wr_data = (temp_valid_ff && temp_addr_ff == scan_ff) ? CODE_TEMP
                                                                        : CODE_NONE;
               end else begin
                  res_value_in = VALUE_W'(scan_ff);
               end
               state_in = ST_POST;
            end else if (scan_ff == '1) begin
               state_in = ST_POST;
            end else begin
               scan_in = scan_ff + maddr_type'(1);
            end
         end
         ST_TEMP_RD: begin
            rd_addr  = addr_ff;
            state_in = ST_TEMP_LOOK;
         end
         ST_TEMP_LOOK: begin
            if (rd_data == CODE_NONE) begin
               wr_en   = 1'b1;
               wr_data = CODE_TEMP;
            end
            state_in = ST_POST;
         end
         ST_POST: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = res_value_ff;
               rsp_found_in = res_found_ff;
               rsp_hit_in   = res_hit_ff;
               state_in     = ST_IDLE;
            end
         end
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = CODE_NONE;
            clr_in  = clr_ff + maddr_type'(1);
            if (clr_ff == '1) begin
               state_in = post_ff ? ST_POST : ST_IDLE;
               post_in  = 1'b0;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         post_ff       <= 1'b0;
         temp_addr_ff  <= '0;
         temp_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         post_ff       <= post_in;
         temp_addr_ff  <= temp_addr_in;
         temp_valid_ff <= temp_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      addr_ff      <= addr_in;
      id_ff        <= id_in;
      scan_ff      <= scan_in;
      res_value_ff <= res_value_in;
      res_found_ff <= res_found_in;
      res_hit_ff   <= res_hit_in;
      rsp_value_ff <= rsp_value_in;
      rsp_found_ff <= rsp_found_in;
      rsp_hit_ff   <= rsp_hit_in;
   end

   assign req_stall    = (state_ff != ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_value    = rsp_value_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_hit_kind = rsp_hit_ff;

   // an accepted item always goes to the lookup step next
   a_accept_look: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_LOOK))
      else $error("accepted item did not enter lookup");

   // a result is only staged from a step that produced it
   a_post_source: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_POST && $past(state_ff) != ST_POST) |->
      ($past(state_ff) == ST_LOOK || $past(state_ff) == ST_SCAN ||
       $past(state_ff) == ST_TEMP_LOOK || $past(state_ff) == ST_CLEAR))
      else $error("result staged from an unexpected step");

   // a write during a scan ends the scan
   a_scan_write_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && wr_en) |=> (state_ff == ST_POST))
      else $error("scan continued after clearing an entry");

   // the temporary breakpoint only appears through set_temp
   a_temp_rise: assert property (@(posedge clock) disable iff (reset)
      $rose(temp_valid_ff) |-> $past(cmd_ff == CMD_SET_TEMP && state_ff == ST_LOOK))
      else $error("temporary breakpoint set without set_temp");

   // the clearing sweep stops once the last address is written
   a_clear_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR && clr_ff == '1) |=> (state_ff != ST_CLEAR))
      else $error("clearing sweep did not stop at the last entry");

endmodule

`default_nettype wire
